/* rtl/rotate_scale_source_address_defines.svh */
// ----------------------------------------------------------------------------
// rotate_scale_source_address assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROTATE_SCALE_SOURCE_ADDRESS_DEFINES_SVH
`define ROTATE_SCALE_SOURCE_ADDRESS_DEFINES_SVH
`ifndef SYNTH
`define RSSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RSSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RSSA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define RSSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/rssa_pkg.sv */
// ----------------------------------------------------------------------------
// rssa_pkg
// Shared types, register map and width helpers for the source address block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rssa_pkg;

   localparam int CENTER_W   = 17;
   localparam int TRIG_W     = 16;
   localparam int INV_W      = 17;
   localparam int SIZE_W     = 13;
   localparam int BPP_W      = 3;
   localparam int ADDR_W     = 26;
   localparam int SCALE_FRAC = 16;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int NSTG       = 9;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_CENTER_X    = 3'd0,
      REG_CENTER_Y    = 3'd1,
      REG_COS_Q       = 3'd2,
      REG_SIN_Q       = 3'd3,
      REG_INV_SCALE_Q = 3'd4,
      REG_IMG_WIDTH   = 3'd5,
      REG_IMG_HEIGHT  = 3'd6,
      REG_BPP         = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic signed [TRIG_W-1:0]   cos_q;
      logic signed [TRIG_W-1:0]   sin_q;
      logic [INV_W-1:0]           inv_scale_q;
      logic [SIZE_W-1:0]          img_width;
      logic [SIZE_W-1:0]          img_height;
      logic [BPP_W-1:0]           bytes_per_pixel;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      center_x:        17'sd0,
      center_y:        17'sd0,
      cos_q:           16'sd16384,
      sin_q:           16'sd0,
      inv_scale_q:     17'd65536,
      img_width:       13'd1,
      img_height:      13'd1,
      bytes_per_pixel: 3'd3
   };

   // width of the centered offset dest - center
   function automatic int dx_width(int coord_bits);
      return ((coord_bits + 1 > CENTER_W) ? coord_bits + 1 : CENTER_W) + 1;
   endfunction

   // width of (rotated offset) * inv_scale
   function automatic int prod_width(int coord_bits);
      return dx_width(coord_bits) + TRIG_W + 1 + INV_W + 1;
   endfunction

endpackage

/* rtl/rssa_rotate.sv */
// ----------------------------------------------------------------------------
// rssa_rotate
// Offset, rotation products, rotated sums and scale product: four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rssa_rotate import rssa_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                                         clock,
   input  logic [3:0]                                   en,
   input  cfg_type                                      cfg,
   input  logic [COORD_BITS-1:0]                        dest_x,
   input  logic [COORD_BITS-1:0]                        dest_y,
   output logic signed [prod_width(COORD_BITS)-1:0]     prod_x,
   output logic signed [prod_width(COORD_BITS)-1:0]     prod_y
);

   localparam int DX_W  = dx_width(COORD_BITS);
   localparam int DP_W  = DX_W + TRIG_W;
   localparam int SUM_W = DP_W + 1;
   localparam int PR_W  = prod_width(COORD_BITS);

   logic signed [DX_W-1:0]  dx_in, dx_ff, dy_in, dy_ff;
   logic signed [DP_W-1:0]  dxc_in, dxc_ff, dys_in, dys_ff;
   logic signed [DP_W-1:0]  dyc_in, dyc_ff, dxs_in, dxs_ff;
   logic signed [SUM_W-1:0] px_in, px_ff, py_in, py_ff;
   logic signed [PR_W-1:0]  prx_in, prx_ff, pry_in, pry_ff;
   logic signed [PR_W-1:0]  inv_s;

   assign dx_in  = DX_W'($signed({1'b0, dest_x})) - DX_W'(cfg.center_x);
   assign dy_in  = DX_W'($signed({1'b0, dest_y})) - DX_W'(cfg.center_y);

   assign dxc_in = DP_W'(dx_ff) * DP_W'(cfg.cos_q);
   assign dys_in = DP_W'(dy_ff) * DP_W'(cfg.sin_q);
   assign dyc_in = DP_W'(dy_ff) * DP_W'(cfg.cos_q);
   assign dxs_in = DP_W'(dx_ff) * DP_W'(cfg.sin_q);

   assign px_in  = SUM_W'(dxc_ff) + SUM_W'(dys_ff);
   assign py_in  = SUM_W'(dyc_ff) - SUM_W'(dxs_ff);

   assign inv_s  = PR_W'($signed({1'b0, cfg.inv_scale_q}));
   assign prx_in = PR_W'(px_ff) * inv_s;
   assign pry_in = PR_W'(py_ff) * inv_s;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (en[1]) begin
         dxc_ff <= dxc_in;
         dys_ff <= dys_in;
         dyc_ff <= dyc_in;
         dxs_ff <= dxs_in;
      end
      if (en[2]) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (en[3]) begin
         prx_ff <= prx_in;
         pry_ff <= pry_in;
      end
   end

   assign prod_x = prx_ff;
   assign prod_y = pry_ff;

endmodule

/* rtl/rssa_locate.sv */
// ----------------------------------------------------------------------------
// rssa_locate
// Recenter, truncate toward zero, bounds check and flipped row: two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rssa_locate import rssa_pkg::*; #(
   parameter int COORD_BITS     = 12,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                     clock,
   input  logic [1:0]                               en,
   input  logic signed [prod_width(COORD_BITS)-1:0] prod_x,
   input  logic signed [prod_width(COORD_BITS)-1:0] prod_y,
   input  logic [COORD_BITS:0]                      w_cl,
   input  logic [COORD_BITS:0]                      h_cl,
   output logic                                     in_image,
   output logic [COORD_BITS-1:0]                    src_x,
   output logic [COORD_BITS-1:0]                    src_y,
   output logic [COORD_BITS-1:0]                    row
);

   localparam int PR_W = prod_width(COORD_BITS);
   localparam int F    = TRIG_FRAC_BITS + SCALE_FRAC;
   localparam int QW   = PR_W - F + 1;
   localparam int SZ_W = COORD_BITS + 1;

   logic signed [QW-1:0]   qx_in, qx_ff, qy_in, qy_ff;
   logic                   fx_in, fx_ff, fy_in, fy_ff;
   logic signed [QW-1:0]   sx_full, sy_full;
   logic [SZ_W-1:0]        row_full;
   logic                   in_in, in_ff;
   logic [COORD_BITS-1:0]  sx_in, sx_ff, sy_in, sy_ff, row_in, row_ff;

   // floor of the integer part plus half size; fraction flag for truncation
   assign qx_in = QW'(prod_x >>> F) + QW'($signed({1'b0, w_cl[SZ_W-1:1]}));
   assign qy_in = QW'(prod_y >>> F) + QW'($signed({1'b0, h_cl[SZ_W-1:1]}));
   assign fx_in = |prod_x[F-1:0];
   assign fy_in = |prod_y[F-1:0];

   assign sx_full = qx_ff + QW'($signed({1'b0, qx_ff[QW-1] & fx_ff}));
   assign sy_full = qy_ff + QW'($signed({1'b0, qy_ff[QW-1] & fy_ff}));

   assign in_in = !sx_full[QW-1] && ($unsigned(sx_full) < QW'(w_cl)) &&
                  !sy_full[QW-1] && ($unsigned(sy_full) < QW'(h_cl));
   assign sx_in = sx_full[COORD_BITS-1:0];
   assign sy_in = sy_full[COORD_BITS-1:0];

   assign row_full = h_cl - SZ_W'(1) - SZ_W'(sy_in);
   assign row_in   = row_full[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
      if (en[1]) begin
         in_ff  <= in_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         row_ff <= row_in;
      end
   end

   assign in_image = in_ff;
   assign src_x    = sx_ff;
   assign src_y    = sy_ff;
   assign row      = row_ff;

endmodule

/* rtl/rssa_address.sv */
// ----------------------------------------------------------------------------
// rssa_address
// Row times width, add column, times pixel size, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rssa_address import rssa_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic [2:0]             en,
   input  logic                   in_image,
   input  logic [COORD_BITS-1:0]  src_x,
   input  logic [COORD_BITS-1:0]  src_y,
   input  logic [COORD_BITS-1:0]  row,
   input  logic [COORD_BITS:0]    w_cl,
   input  logic [BPP_W-1:0]       bpp,
   output logic                   out_inside,
   output logic [COORD_BITS-1:0]  out_src_x,
   output logic [COORD_BITS-1:0]  out_src_y,
   output logic [ADDR_W-1:0]      out_addr
);

   localparam int RW_W  = 2 * COORD_BITS + 1;
   localparam int MUL_W = (RW_W + BPP_W > ADDR_W) ? RW_W + BPP_W : ADDR_W;

   logic [RW_W-1:0]       m_in, m_ff, t_in, t_ff;
   logic [MUL_W-1:0]      full_addr;
   logic                  in7_ff, in8_ff, in9_ff;
   logic [COORD_BITS-1:0] sx7_ff, sy7_ff, sx8_ff, sy8_ff;
   logic [COORD_BITS-1:0] sx9_in, sx9_ff, sy9_in, sy9_ff;
   logic [ADDR_W-1:0]     addr_in, addr_ff;

   assign m_in      = RW_W'(row) * RW_W'(w_cl);
   assign t_in      = m_ff + RW_W'(sx7_ff);
   assign full_addr = MUL_W'(t_ff) * MUL_W'(bpp);
   assign addr_in   = in8_ff ? full_addr[ADDR_W-1:0] : '0;
   assign sx9_in    = in8_ff ? sx8_ff : '0;
   assign sy9_in    = in8_ff ? sy8_ff : '0;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         m_ff   <= m_in;
         in7_ff <= in_image;
         sx7_ff <= src_x;
         sy7_ff <= src_y;
      end
      if (en[1]) begin
         t_ff   <= t_in;
         in8_ff <= in7_ff;
         sx8_ff <= sx7_ff;
         sy8_ff <= sy7_ff;
      end
      if (en[2]) begin
         addr_ff <= addr_in;
         in9_ff  <= in8_ff;
         sx9_ff  <= sx9_in;
         sy9_ff  <= sy9_in;
      end
   end

   assign out_inside = in9_ff;
   assign out_src_x  = sx9_ff;
   assign out_src_y  = sy9_ff;
   assign out_addr   = addr_ff;

endmodule

/* rtl/rotate_scale_source_address.sv */
// ----------------------------------------------------------------------------
// rotate_scale_source_address
// Maps a destination pixel back into a rotated, scaled source image.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per destination pixel, dest_x and dest_y in tdata.
//   rsp_*  : one beat per request beat, in order; tuser is the inside flag,
//            tdata carries src_x, src_y and the bottom-up byte address,
//            all zero when the point falls outside the image.
//   csr_*  : register writes, index order center_x, center_y, cos_q, sin_q,
//            inv_scale_q, img_width, img_height, bytes_per_pixel. Write only
//            while no beat is in flight.
// Throughput: one beat per cycle while rsp_tready is high. A request passes
//   through the 9-stage datapath (offset, four products, sums, scale product,
//   recenter, truncate/bounds, row product, column add, pixel-size product
//   with the output register) before its response raises rsp_tvalid.
// Reset clears all stage valid bits and loads the register defaults.
// When rsp_tready is low the output stage holds; req_tready stays high while
//   any stage is empty, so bubbles fill before the request side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotate_scale_source_address_defines.svh"

module rotate_scale_source_address import rssa_pkg::*; #(
   parameter int COORD_BITS     = 12,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // dest_x, dest_y
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]            req_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // src_x, src_y, byte_address
   output logic [((2*COORD_BITS+ADDR_W+7)/8)*8-1:0]     rsp_tdata,
   // inside_res
   output logic                                         rsp_tuser,
   input  logic                                         csr_we,
   input  logic [REG_IDX_W-1:0]                         csr_addr,
   input  logic [CSR_DATA_W-1:0]                        csr_wdata
);

   localparam int RSP_W = ((2*COORD_BITS+ADDR_W+7)/8)*8;
   localparam int PR_W  = prod_width(COORD_BITS);
   localparam int SZ_W  = COORD_BITS + 1;
   localparam int CMP_W = (SIZE_W > SZ_W) ? SIZE_W : SZ_W;
   localparam logic [CMP_W-1:0] SIZE_LIM = CMP_W'(1) << COORD_BITS;

   cfg_type                  cfg_in, cfg_ff;
   logic [NSTG-1:0]          v_in, v_ff, rdy;
   logic [SZ_W-1:0]          w_cl, h_cl;
   logic [CMP_W-1:0]         w_cmp, h_cmp;
   logic signed [PR_W-1:0]   prod_x, prod_y;
   logic                     loc_inside;
   logic [COORD_BITS-1:0]    loc_sx, loc_sy, loc_row;
   logic                     rsp_inside;
   logic [COORD_BITS-1:0]    rsp_src_x, rsp_src_y;
   logic [ADDR_W-1:0]        rsp_addr;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_idx_type'(csr_addr))
            REG_CENTER_X:    cfg_in.center_x        = CENTER_W'($signed(csr_wdata));
            REG_CENTER_Y:    cfg_in.center_y        = CENTER_W'($signed(csr_wdata));
            REG_COS_Q:       cfg_in.cos_q           = $signed(csr_wdata[TRIG_W-1:0]);
            REG_SIN_Q:       cfg_in.sin_q           = $signed(csr_wdata[TRIG_W-1:0]);
            REG_INV_SCALE_Q: cfg_in.inv_scale_q     = csr_wdata[INV_W-1:0];
            REG_IMG_WIDTH:   cfg_in.img_width       = csr_wdata[SIZE_W-1:0];
            REG_IMG_HEIGHT:  cfg_in.img_height      = csr_wdata[SIZE_W-1:0];
            REG_BPP:         cfg_in.bytes_per_pixel = csr_wdata[BPP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sizes clamped to the coordinate range
   assign w_cmp = CMP_W'(cfg_ff.img_width);
   assign h_cmp = CMP_W'(cfg_ff.img_height);
   assign w_cl  = (w_cmp > SIZE_LIM) ? SZ_W'(SIZE_LIM) : SZ_W'(w_cmp);
   assign h_cl  = (h_cmp > SIZE_LIM) ? SZ_W'(SIZE_LIM) : SZ_W'(h_cmp);

   // stage valids; a stage loads when empty or when the next one loads
   always_comb begin
      rdy[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign v_in = (rdy & {v_ff[NSTG-2:0], req_tvalid}) | (~rdy & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = v_ff[NSTG-1];

   rssa_rotate #(
      .COORD_BITS (COORD_BITS)
   ) u_rotate (
      .clock  (clock),
      .en     (rdy[3:0]),
      .cfg    (cfg_ff),
      .dest_x (req_tdata[COORD_BITS-1:0]),
      .dest_y (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .prod_x (prod_x),
      .prod_y (prod_y)
   );

   rssa_locate #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_locate (
      .clock    (clock),
      .en       (rdy[5:4]),
      .prod_x   (prod_x),
      .prod_y   (prod_y),
      .w_cl     (w_cl),
      .h_cl     (h_cl),
      .in_image (loc_inside),
      .src_x    (loc_sx),
      .src_y    (loc_sy),
      .row      (loc_row)
   );

   rssa_address #(
      .COORD_BITS (COORD_BITS)
   ) u_address (
      .clock      (clock),
      .en         (rdy[8:6]),
      .in_image   (loc_inside),
      .src_x      (loc_sx),
      .src_y      (loc_sy),
      .row        (loc_row),
      .w_cl       (w_cl),
      .bpp        (cfg_ff.bytes_per_pixel),
      .out_inside (rsp_inside),
      .out_src_x  (rsp_src_x),
      .out_src_y  (rsp_src_y),
      .out_addr   (rsp_addr)
   );

   assign rsp_tuser = rsp_inside;
   assign rsp_tdata = RSP_W'({rsp_addr, rsp_src_y, rsp_src_x});

   `RSSA_ASSERT_SAME(a_outside_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "outside beat carries nonzero data")
   `RSSA_ASSERT_SAME(a_bubble_ready, clock, reset, $countones(v_ff) < NSTG, req_tready, "request stalled with an empty stage")
   `RSSA_ASSERT_NEXT(a_beat_count, clock, reset, !reset, $countones(v_ff) == $past($countones(v_ff)) + $past(req_tvalid && req_tready) - $past(rsp_tvalid && rsp_tready), "beats lost or duplicated in pipeline")

endmodule
